FILE: hw/rtl/ssbg_pkg.sv
// constants and register codes for the sensor smoothing bar graph
`timescale 1ns / 1ps
`default_nettype none

package ssbg_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int SUM_W       = 16;
    localparam int MASK_W      = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int EMA_NUM_W   = 17;
    localparam int THR_NUM_W   = 16;
    localparam int RECIP_EXTRA = 5;

    localparam int WINDOW_DEF   = 10;
    localparam int BAR_LEDS_DEF = 10;

    localparam logic                SHOW_RESET    = 1'b1;
    localparam logic [SAMPLE_W-1:0] BAR_MIN_RESET = 12'd100;
    localparam logic [SAMPLE_W-1:0] BAR_MAX_RESET = 12'd1100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHOW_SMOOTHED = 2'd0,
        CFG_BAR_MIN       = 2'd1,
        CFG_BAR_MAX       = 2'd2
    } cfg_idx_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sensor_smoothing_bar_graph.sv
// moving average, exponential average and bar-graph mask of a millivolt stream
//
//   channel   signals                               direction
//   input     in_valid in_ready sample_mv           item in
//   output    out_valid out_ready average_mv        item out
//             smoothed_mv bar_mask
//   config    cfg_valid cfg_ready cfg_index cfg_data  register write
//
// one item per cycle while out_ready is high; results pass stage 1, stage 2, output register
// the sample history sits in a small synchronous ram read on accept, written when the
// item leaves stage 1 and the running sum and average are updated
// every stage stalls on its own, so a new item enters while a result waits
// reset clears the history through per-entry valid bits, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module sensor_smoothing_bar_graph #(
    parameter int WINDOW   = ssbg_pkg::WINDOW_DEF,
    parameter int BAR_LEDS = ssbg_pkg::BAR_LEDS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [ssbg_pkg::SAMPLE_W-1:0]       sample_mv,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [ssbg_pkg::SAMPLE_W-1:0]            average_mv,
    output logic [ssbg_pkg::SAMPLE_W-1:0]            smoothed_mv,
    output logic [ssbg_pkg::MASK_W-1:0]              bar_mask,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ssbg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ssbg_pkg::SAMPLE_W-1:0]       cfg_data
);

    localparam int SW      = ssbg_pkg::SAMPLE_W;
    localparam int SUMW    = ssbg_pkg::SUM_W;
    localparam int MW      = ssbg_pkg::MASK_W;
    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int LIT_N   = (BAR_LEDS < MW) ? BAR_LEDS : MW;

    // reciprocal constants, exact floor division for numerators below 2^N
    localparam int AVG_K   = SUMW + ssbg_pkg::RECIP_EXTRA;
    localparam int AVG_M   = ((1 << AVG_K) + WINDOW - 1) / WINDOW;
    localparam int AVG_PW  = SUMW + AVG_K + 1;

    localparam int EMA_NW  = ssbg_pkg::EMA_NUM_W;
    localparam int EMA_D   = WINDOW + 1;
    localparam int EMA_K   = EMA_NW + ssbg_pkg::RECIP_EXTRA;
    localparam int EMA_M   = ((1 << EMA_K) + EMA_D - 1) / EMA_D;
    localparam int EMA_PW  = EMA_NW + EMA_K + 1;
    localparam int EMA_HLF = EMA_D / 2;

    localparam int THR_NW  = ssbg_pkg::THR_NUM_W;
    localparam int THR_K   = THR_NW + ssbg_pkg::RECIP_EXTRA;
    localparam int THR_M   = ((1 << THR_K) + BAR_LEDS - 1) / BAR_LEDS;
    localparam int THR_PW  = THR_NW + THR_K + 1;

    // configuration registers
    logic          show_reg;
    logic [SW-1:0] bar_min_reg;
    logic [SW-1:0] bar_max_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            show_reg    <= ssbg_pkg::SHOW_RESET;
            bar_min_reg <= ssbg_pkg::BAR_MIN_RESET;
            bar_max_reg <= ssbg_pkg::BAR_MAX_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ssbg_pkg::CFG_SHOW_SMOOTHED: show_reg    <= cfg_data[0];
                ssbg_pkg::CFG_BAR_MIN:       bar_min_reg <= cfg_data;
                ssbg_pkg::CFG_BAR_MAX:       bar_max_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // stage handshakes
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_en;
    logic s2_en;
    logic s1_en;
    logic s1_move;
    logic s2_move;
    logic in_fire;

    assign out_en   = !out_valid_reg || out_ready;
    assign s2_en    = !s2_valid_reg || out_en;
    assign s2_move  = s2_valid_reg && out_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign s1_move  = s1_valid_reg && s2_en;
    assign in_ready = s1_en;
    assign in_fire  = in_valid && s1_en;

    // history ram with per-entry valid bits
    logic [SW-1:0]     hist_mem [WINDOW];
    logic [WINDOW-1:0] hist_vld_reg;
    logic [SW-1:0]     rd_data_reg;
    logic              rd_vld_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [SW-1:0]     s1_x_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic              s1_show_reg;
    logic [SW-1:0]     s1_min_reg;

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            hist_mem[s1_slot_reg] <= s1_x_reg;
        end
        if (in_fire)
        begin
            rd_data_reg <= hist_mem[slot_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
            slot_reg     <= '0;
        end
        else
        begin
            if (s1_move)
            begin
                hist_vld_reg[s1_slot_reg] <= 1'b1;
            end
            if (in_fire)
            begin
                rd_vld_reg <= hist_vld_reg[slot_reg];
                slot_reg   <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            end
        end
    end

    // stage 1: item captured, span products formed
    logic [SW-1:0] span;

    assign span = (bar_max_reg >= bar_min_reg) ? (bar_max_reg - bar_min_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_x_reg    <= sample_mv;
            s1_slot_reg <= slot_reg;
            s1_show_reg <= show_reg;
            s1_min_reg  <= bar_min_reg;
        end
    end

    // stage 1 -> 2: running sum, average and exponential average
    logic [SUMW-1:0]   sum_reg;
    logic [SUMW-1:0]   sum_next;
    logic [SW-1:0]     old_val;
    logic [AVG_PW-1:0] avg_prod;
    logic [EMA_NW-1:0] ema_num;
    logic [EMA_PW-1:0] ema_prod;
    logic [SW-1:0]     ema_next;
    logic [SW-1:0]     ema_reg;

    assign old_val  = rd_vld_reg ? rd_data_reg : '0;
    assign sum_next = sum_reg - SUMW'(old_val) + SUMW'(s1_x_reg);
    assign avg_prod = AVG_PW'(sum_next) * AVG_PW'(AVG_M);
    assign ema_num  = EMA_NW'({s1_x_reg, 1'b0}) + EMA_NW'(ema_reg) * EMA_NW'(WINDOW - 1)
                    + EMA_NW'(EMA_HLF);
    assign ema_prod = EMA_PW'(ema_num) * EMA_PW'(EMA_M);
    assign ema_next = ema_prod[EMA_K +: SW];

    logic [SW-1:0] s2_avg_reg;
    logic [SW-1:0] s2_ema_reg;
    logic [SW-1:0] s2_shown_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            ema_reg       <= '0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= s2_valid_reg;
            end
            if (s1_move)
            begin
                sum_reg <= sum_next;
                ema_reg <= ema_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_avg_reg   <= avg_prod[AVG_K +: SW];
            s2_ema_reg   <= ema_next;
            s2_shown_reg <= s1_show_reg ? ema_next : s1_x_reg;
        end
    end

    // per-led thresholds: product at accept, scaled and offset at stage 1
    logic [MW-1:0] mask_next;

    genvar gi;
    generate
        for (gi = 0; gi < MW; gi++)
        begin : g_led
            if (gi < LIT_N)
            begin : g_lit
                logic [THR_NW-1:0] prod_reg;
                logic [THR_PW-1:0] scaled;
                logic [SW-1:0]     thr_reg;

                assign scaled = THR_PW'(prod_reg) * THR_PW'(THR_M);

                always_ff @(posedge clk)
                begin
                    if (in_fire)
                    begin
                        prod_reg <= THR_NW'(span) * THR_NW'(BAR_LEDS - 1 - gi);
                    end
                    if (s1_move)
                    begin
                        thr_reg <= s1_min_reg + scaled[THR_K +: SW];
                    end
                end

                assign mask_next[gi] = (s2_shown_reg < thr_reg);
            end
            else
            begin : g_off
                assign mask_next[gi] = 1'b0;
            end
        end
    endgenerate

    // output register
    logic [SW-1:0] avg_out_reg;
    logic [SW-1:0] ema_out_reg;
    logic [MW-1:0] mask_out_reg;

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            avg_out_reg  <= s2_avg_reg;
            ema_out_reg  <= s2_ema_reg;
            mask_out_reg <= mask_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign average_mv  = avg_out_reg;
    assign smoothed_mv = ema_out_reg;
    assign bar_mask    = mask_out_reg;

endmodule

`default_nettype wire
